// ===== hdl/rrbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbs_pkg
// Shared widths, codes and the controller-to-datapath command word for the
// round-robin burst scheduler.
// ----------------------------------------------------------------------------
package rrbs_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int ID_W     = 16;
    localparam int TIME_W   = 16;
    localparam int STATUS_W = 2;

    // action field
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // status field
    localparam logic [STATUS_W-1:0] STAT_ADDED   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RAN     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_IDLE    = 2'd3;

    typedef struct packed {
        logic load;   // capture the input word, read the tables at current slot
        logic exec;   // carry out the add or tick, register the result
    } rrbs_cmd_t;

endpackage

// ===== hdl/rrbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrbs_ctrl
// Two-state sequencer: capture a word, then execute it and strobe the result.
// ----------------------------------------------------------------------------
module rrbs_ctrl
    import rrbs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output rrbs_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        done_next = cmd.exec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== hdl/rrbs_datapath.sv =====
// ----------------------------------------------------------------------------
// rrbs_datapath
// Slot tables, live mask, pointers, next-live search and result registers.
// ----------------------------------------------------------------------------
module rrbs_datapath
    import rrbs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rrbs_cmd_t           cmd,
    input  logic                action,
    input  logic [ID_W-1:0]     proc_id,
    input  logic [TIME_W-1:0]   burst_time,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     run_id,
    output logic [TIME_W-1:0]   time_left,
    output logic                finished,
    output logic                now_empty
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    // one-hot to index: each index bit is an OR over the positions carrying it
    function automatic logic [IDX_W-1:0] onehot_idx(input logic [SLOTS-1:0] oh);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < IDX_W; b++)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    idx[b] = idx[b] | oh[i];
                end
            end
        end
        return idx;
    endfunction

    // tables
    logic [ID_W-1:0]   id_mem   [SLOTS];
    logic [TIME_W-1:0] time_mem [SLOTS];
    logic [ID_W-1:0]   rd_id_reg;
    logic [TIME_W-1:0] rd_time_reg;

    // captured input word
    logic              action_reg;
    logic [ID_W-1:0]   id_in_reg;
    logic [TIME_W-1:0] burst_in_reg;

    // control state
    logic [SLOTS-1:0]  live_reg, live_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // result
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ID_W-1:0]     run_id_reg, run_id_next;
    logic [TIME_W-1:0]   left_reg, left_next;
    logic                fin_reg, fin_next;
    logic                empty_reg;

    // table write port
    logic              id_we, time_we;
    logic [IDX_W-1:0]  wr_addr;
    logic [TIME_W-1:0] time_wdata;

    // tick path
    logic [TIME_W-1:0] t_dec;
    logic              t_zero;
    logic              can_run;
    logic [SLOTS-1:0]  cur_bit, tail_bit;
    logic [SLOTS-1:0]  live_after;
    logic [SLOTS-1:0]  le_mask, hi_cand, wrap_cand, cand, pick;

    assign cur_bit  = SLOTS'(1) << cur_reg;
    assign tail_bit = SLOTS'(1) << tail_reg;

    assign t_dec   = (rd_time_reg != '0) ? rd_time_reg - TIME_W'(1) : '0;
    assign t_zero  = (t_dec == '0);
    assign can_run = (cnt_reg != '0) && live_reg[cur_reg];

    // search order after current: slots above it first, then wrap round to
    // slot zero up to and including current itself
    assign live_after = (can_run && t_zero) ? (live_reg & ~cur_bit) : live_reg;
    assign le_mask    = {SLOTS{1'b1}} >> (LAST - cur_reg);
    assign hi_cand    = live_after & ~le_mask;
    assign wrap_cand  = live_after & le_mask;
    assign cand       = (|hi_cand) ? hi_cand : wrap_cand;
    assign pick       = cand & (~cand + SLOTS'(1));

    always_comb
    begin
        live_next   = live_reg;
        cur_next    = cur_reg;
        tail_next   = tail_reg;
        cnt_next    = cnt_reg;
        status_next = STAT_IDLE;
        run_id_next = '0;
        left_next   = '0;
        fin_next    = 1'b0;
        id_we       = 1'b0;
        time_we     = 1'b0;
        wr_addr     = tail_reg;
        time_wdata  = burst_in_reg;

        if (action_reg == ACT_ADD)
        begin
            if (live_reg[tail_reg])
            begin
                status_next = STAT_REFUSED;
            end
            else
            begin
                status_next = STAT_ADDED;
                id_we       = cmd.exec;
                time_we     = cmd.exec;
                live_next   = live_reg | tail_bit;
                if (cnt_reg == '0)
                begin
                    cur_next = tail_reg;
                end
                cnt_next  = cnt_reg + CNT_W'(1);
                tail_next = (tail_reg == LAST) ? '0 : tail_reg + IDX_W'(1);
            end
        end
        else if (can_run)
        begin
            status_next = STAT_RAN;
            run_id_next = rd_id_reg;
            left_next   = t_dec;
            fin_next    = t_zero;
            time_we     = cmd.exec;
            wr_addr     = cur_reg;
            time_wdata  = t_dec;
            live_next   = live_after;
            cnt_next    = t_zero ? cnt_reg - CNT_W'(1) : cnt_reg;
            if (|cand)
            begin
                cur_next = onehot_idx(pick);
            end
        end
    end

    // tables: one write port, one registered read at current slot
    always_ff @(posedge clk)
    begin
        if (id_we)
        begin
            id_mem[wr_addr] <= id_in_reg;
        end
        if (time_we)
        begin
            time_mem[wr_addr] <= time_wdata;
        end
        if (cmd.load)
        begin
            rd_id_reg   <= id_mem[cur_reg];
            rd_time_reg <= time_mem[cur_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg   <= action;
            id_in_reg    <= proc_id;
            burst_in_reg <= burst_time;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            run_id_reg <= run_id_next;
            left_reg   <= left_next;
            fin_reg    <= fin_next;
            empty_reg  <= (cnt_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            cur_reg  <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            live_reg <= live_next;
            cur_reg  <= cur_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign status    = status_reg;
    assign run_id    = run_id_reg;
    assign time_left = left_reg;
    assign finished  = fin_reg;
    assign now_empty = empty_reg;

endmodule

// ===== hdl/round_robin_burst_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_burst_scheduler
// Round-robin scheduler, quantum of one tick, over a circular slot table.
//
//   channel  | signals                                   | handshake
//   ---------+-------------------------------------------+----------------------
//   command  | action, proc_id, burst_time               | start high, busy low
//   result   | status, run_id, time_left, finished,      | done high for one
//            | now_empty                                 | cycle, no back-pressure
//
// For every word, the accept edge captures it and reads the tables at the
// current slot; the next edge writes back, moves the pointers and registers
// the result. done is high in the cycle after, with busy low, so the next
// word is taken at the edge that ends it; busy holds off a new word until
// then. Reset clears the live mask, pointers and count; the tables are not
// cleared, as only live entries are ever used. The receiver cannot stall.
// ----------------------------------------------------------------------------
module round_robin_burst_scheduler
    import rrbs_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                action,
    input  logic [ID_W-1:0]     proc_id,
    input  logic [TIME_W-1:0]   burst_time,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [ID_W-1:0]     run_id,
    output logic [TIME_W-1:0]   time_left,
    output logic                finished,
    output logic                now_empty
);

    rrbs_cmd_t cmd;

    // sequencer: idle / execute
    rrbs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // tables, live mask, pointers and the next-live search
    rrbs_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .action     (action),
        .proc_id    (proc_id),
        .burst_time (burst_time),
        .status     (status),
        .run_id     (run_id),
        .time_left  (time_left),
        .finished   (finished),
        .now_empty  (now_empty)
    );

endmodule

// ===== bench/round_robin_burst_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_burst_scheduler_test
// Self-checking bench for the round-robin burst scheduler. A short directed
// table (reset idle, id and burst extremes, zero burst, last process leaving,
// full-table refusal) is followed by random fill/drain traffic. Each result
// word is checked against its typed row or an in-bench scheduling predictor.
// ----------------------------------------------------------------------------
module round_robin_burst_scheduler_test;

    import rrbs_pkg::*;

    localparam int SLOTS       = SLOTS_DEFAULT;
    localparam int QUIET_LIMIT = 2000;   // cycles with no word moving either way
    localparam int RAND_PHASE  = 225;    // random words per idling phase

    // One result word, as the block reports it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     run_id;
        logic [TIME_W-1:0]   time_left;
        logic                finished;
        logic                now_empty;
    } sched_result_t;

    // One row of the directed table. Where typed is set, want holds the
    // result read straight off the scheduling rules; otherwise the
    // predictor supplies it.
    typedef struct {
        logic              act;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] burst;
        bit                typed;
        sched_result_t     want;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                action = ACT_ADD;
    logic [ID_W-1:0]     proc_id = '0;
    logic [TIME_W-1:0]   burst_time = '0;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     run_id;
    logic [TIME_W-1:0]   time_left;
    logic                finished;
    logic                now_empty;

    // Predictor copy of the scheduler state.
    logic [ID_W-1:0]     slot_id   [SLOTS];
    logic [TIME_W-1:0]   slot_time [SLOTS];
    logic [SLOTS-1:0]    live_slots = '0;
    int                  cur_slot   = 0;
    int                  tail_ptr   = 0;
    int                  live_total = 0;

    sched_result_t       due_results[$];
    plan_row_t           plan[$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;

    always #4 clk = ~clk;

    round_robin_burst_scheduler #(
        .SLOTS      (SLOTS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .proc_id    (proc_id),
        .burst_time (burst_time),
        .done       (done),
        .status     (status),
        .run_id     (run_id),
        .time_left  (time_left),
        .finished   (finished),
        .now_empty  (now_empty)
    );

    // ------------------------------------------------------------------------
    // Scheduling predictor: applies one accepted word to the bench copy of
    // the slot table and returns the result word the block should report.
    // ------------------------------------------------------------------------
    function automatic sched_result_t schedule_word(input logic act,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [TIME_W-1:0] burst);
        sched_result_t     res;
        logic [TIME_W-1:0] remaining;
        int                idx;
        bit                found;
        res = '0;
        if (act == ACT_ADD)
        begin
            if (live_slots[tail_ptr])
            begin
                // tail slot still live: refused even if others are free
                res.status = STAT_REFUSED;
            end
            else
            begin
                slot_id[tail_ptr]   = id;
                slot_time[tail_ptr] = burst;
                live_slots[tail_ptr] = 1'b1;
                if (live_total == 0)
                    cur_slot = tail_ptr;
                live_total++;
                tail_ptr   = (tail_ptr + 1) % SLOTS;
                res.status = STAT_ADDED;
            end
        end
        else if (live_total == 0 || !live_slots[cur_slot])
        begin
            res.status = STAT_IDLE;
        end
        else
        begin
            // charge one unit, saturating at zero for a zero burst
            remaining = slot_time[cur_slot];
            if (remaining != '0)
                remaining = remaining - TIME_W'(1);
            slot_time[cur_slot] = remaining;
            res.status    = STAT_RAN;
            res.run_id    = slot_id[cur_slot];
            res.time_left = remaining;
            if (remaining == '0)
            begin
                live_slots[cur_slot] = 1'b0;
                live_total--;
                res.finished = 1'b1;
            end
            // next live slot in circular order, possibly the same one;
            // with none left the pointer keeps its value
            found = 1'b0;
            for (int k = 1; k <= SLOTS; k++)
            begin
                idx = (cur_slot + k) % SLOTS;
                if (!found && live_slots[idx])
                begin
                    cur_slot = idx;
                    found    = 1'b1;
                end
            end
        end
        res.now_empty = (live_total == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Command side. Entered just after a rising edge. Holds start low for a
    // random number of cycles, then presents the word until it is taken.
    // start is left high on return so back-to-back words never lower and
    // raise it in the same step; the next call or the end of the run
    // lowers it.
    // ------------------------------------------------------------------------
    task automatic issue_word(input logic act, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] burst, input int idle_pct,
                              output sched_result_t predicted);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        action     <= act;
        proc_id    <= id;
        burst_time <= burst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = schedule_word(act, id, burst);
    endtask

    // ------------------------------------------------------------------------
    // Result side: done marks a word for exactly one cycle and cannot be
    // held off, so every done edge is checked against the oldest word due.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        sched_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                $display("%0t: result word with none due: status %0d run_id %h time_left %h",
                         $time, status, run_id, time_left);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    mismatches++;
                end
                if (run_id !== want.run_id)
                begin
                    $display("%0t: run_id expected %h actual %h",
                             $time, want.run_id, run_id);
                    mismatches++;
                end
                if (time_left !== want.time_left)
                begin
                    $display("%0t: time_left expected %h actual %h",
                             $time, want.time_left, time_left);
                    mismatches++;
                end
                if (finished !== want.finished)
                begin
                    $display("%0t: finished expected %b actual %b",
                             $time, want.finished, finished);
                    mismatches++;
                end
                if (now_empty !== want.now_empty)
                begin
                    $display("%0t: now_empty expected %b actual %b",
                             $time, want.now_empty, now_empty);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any word taken or delivered restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && busy === 1'b0) || done === 1'b1)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d words still due",
                         $time, due_results.size());
                $display("FAIL round_robin_burst_scheduler");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        // idling per random phase; the third phase stands for receiver
        // stalls, which this block has no means of taking, so the sender
        // streams there
        int                idle_phase[4] = '{0, 65, 0, 10};
        sched_result_t     predicted;
        logic              act;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] burst;
        int                add_pct;
        int                pick;

        // Directed table.
        // Tick straight after reset: table empty, idle.
        plan.push_back('{ACT_TICK, 16'h0000, 16'h0000, 1'b1,
                         '{STAT_IDLE, 16'h0000, 16'h0000, 1'b0, 1'b1}});
        // Largest id, one-tick burst into the empty table.
        plan.push_back('{ACT_ADD, 16'hFFFF, 16'h0001, 1'b1,
                         '{STAT_ADDED, 16'h0000, 16'h0000, 1'b0, 1'b0}});
        // It runs once and leaves as the last live process.
        plan.push_back('{ACT_TICK, 16'h0000, 16'hFFFF, 1'b1,
                         '{STAT_RAN, 16'hFFFF, 16'h0000, 1'b1, 1'b1}});
        // Pointer kept on the freed slot; table empty again.
        plan.push_back('{ACT_TICK, 16'hFFFF, 16'hFFFF, 1'b1,
                         '{STAT_IDLE, 16'h0000, 16'h0000, 1'b0, 1'b1}});
        // Zero id with a zero burst: charge saturates, finishes at once.
        plan.push_back('{ACT_ADD, 16'h0000, 16'h0000, 1'b1,
                         '{STAT_ADDED, 16'h0000, 16'h0000, 1'b0, 1'b0}});
        plan.push_back('{ACT_TICK, 16'h0000, 16'h0000, 1'b1,
                         '{STAT_RAN, 16'h0000, 16'h0000, 1'b1, 1'b1}});
        // Fill every slot, wrapping the tail round to where it began.
        for (int k = 0; k < SLOTS; k++)
            plan.push_back('{ACT_ADD, 16'hA5C3 ^ (16'h1 << k), 16'((k % 3) + 1),
                             1'b0, '0});
        // Tail slot live: refused.
        plan.push_back('{ACT_ADD, 16'h7FFF, 16'h0002, 1'b1,
                         '{STAT_REFUSED, 16'h0000, 16'h0000, 1'b0, 1'b0}});
        plan.push_back('{ACT_TICK, 16'h1234, 16'h8000, 1'b0, '0});
        plan.push_back('{ACT_TICK, 16'h0000, 16'h0000, 1'b0, '0});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            issue_word(plan[i].act, plan[i].id, plan[i].burst, 0, predicted);
            due_results.push_back(plan[i].typed ? plan[i].want : predicted);
        end

        // Random traffic. Add-heavy stretches fill the table into refusals,
        // tick-heavy ones drain it down to idle. Bursts are mostly short so
        // processes come and go; full-range bursts only appear near the very
        // end, since such a process never leaves and would jam the tail.
        for (int p = 0; p < 4; p++)
        begin
            for (int n = 0; n < RAND_PHASE; n++)
            begin
                add_pct = ((n / 40) % 2 == 0) ? 70 : 15;
                act     = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_TICK;
                id      = ID_W'($urandom);
                pick    = $urandom_range(99);
                if (p == 3 && n >= RAND_PHASE - 75 && pick < 10)
                    burst = TIME_W'($urandom_range(65535, 1));
                else if (pick < 60)
                    burst = TIME_W'($urandom_range(3, 1));
                else if (pick < 92)
                    burst = TIME_W'($urandom_range(24, 4));
                else
                    burst = TIME_W'($urandom_range(255, 1));
                // on a tick the id and burst lines carry noise
                if (act == ACT_TICK)
                    burst = TIME_W'($urandom);
                issue_word(act, id, burst, idle_phase[p], predicted);
                due_results.push_back(predicted);
            end
        end
        start <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        // keep clocking to catch any stray result word
        repeat (6) @(posedge clk);

        if (mismatches == 0)
            $display("PASS round_robin_burst_scheduler");
        else
            $display("FAIL round_robin_burst_scheduler");
        $finish;
    end

endmodule

// ===== round_robin_burst_scheduler.f =====
hdl/rrbs_pkg.sv
hdl/rrbs_ctrl.sv
hdl/rrbs_datapath.sv
hdl/round_robin_burst_scheduler.sv
bench/round_robin_burst_scheduler_test.sv
